// File: design/olist_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// olist_pkg
// Shared constants for the ordered list engine: request codes, status codes
// and the default list depth, plus the signed 32-bit value type.
// ============================================================================
package olist_pkg;

    localparam int DEPTH_DEFAULT = 64;

    // Request codes
    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_POS  = 3'd1;
    localparam logic [2:0] CMD_INS_TAIL = 3'd2;
    localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
    localparam logic [2:0] CMD_DEL_POS  = 3'd4;
    localparam logic [2:0] CMD_DEL_TAIL = 3'd5;
    localparam logic [2:0] CMD_SEARCH   = 3'd6;
    localparam logic [2:0] CMD_LIST     = 3'd7;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef logic signed [31:0] t_value;

endpackage

// File: design/ordered_list_engine.sv
`timescale 1ns / 1ps
// Error results and head/tail appends go through S_EMIT to the output register;
// a shifting insert or delete reads and writes back each moved entry; search
// reads and compares each entry; list all reads, captures and emits each entry.
// One request is in work at a time, as the input stalls until the FSM is idle.
// Reset (synchronous, active low) empties the list; memory is not cleared.
// ============================================================================
// ordered_list_engine
// Ordered list of signed 32-bit values held in one synchronous memory, with
// positional insert/delete by shifting, linear search and full listing.
// ============================================================================
module ordered_list_engine #(
    parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_cmd,
    input  logic [6:0]            i_position,
    input  olist_pkg::t_value     i_item_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output olist_pkg::t_value     o_out_value,
    output logic [6:0]            o_out_position,
    output logic [2:0]            o_status,
    output logic                  o_last
);
    import olist_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > 7) ? CW : 7) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EMIT = 4'd1;
    localparam logic [3:0] S_SHRD = 4'd2;
    localparam logic [3:0] S_SHWR = 4'd3;
    localparam logic [3:0] S_INSV = 4'd4;
    localparam logic [3:0] S_DRD  = 4'd5;
    localparam logic [3:0] S_DCAP = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCMP = 4'd8;
    localparam logic [3:0] S_LRD  = 4'd9;
    localparam logic [3:0] S_LCAP = 4'd10;

    t_value        r_mem [DEPTH];
    t_value        r_rd;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ret, n_ret;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_ins, n_ins;
    t_value        r_val, n_val;

    t_value        r_res_val, n_res_val;
    logic [6:0]    r_res_pos, n_res_pos;
    logic [2:0]    r_res_st, n_res_st;
    logic          r_res_last, n_res_last;

    logic          r_ovalid, n_ovalid;
    t_value        r_oval;
    logic [6:0]    r_opos;
    logic [2:0]    r_ost;
    logic          r_olast;
    logic          out_load;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_value        mem_wdata;

    logic [EW-1:0] pos_e, cnt_e;
    logic          accept, out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign pos_e    = EW'(i_position);
    assign cnt_e    = EW'(r_count);

    // Sequence one request through the memory
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_ins      = r_ins;
        n_val      = r_val;
        n_res_val  = r_res_val;
        n_res_pos  = r_res_pos;
        n_res_st   = r_res_st;
        n_res_last = r_res_last;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_idx;
        mem_raddr  = r_ptr[AW-1:0];
        mem_wdata  = r_val;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val      = i_item_value;
                    n_res_val  = '0;
                    n_res_pos  = '0;
                    n_res_st   = ST_OK;
                    n_res_last = 1'b1;
                    n_ret      = S_IDLE;
                    n_state    = S_EMIT;
                    case (i_cmd)
                        CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
                            n_ins = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_res_st = ST_FULL;
                            end else if (i_cmd == CMD_INS_POS &&
                                         (pos_e == '0 || pos_e > cnt_e + 1'b1)) begin
                                n_res_st = ST_BADPOS;
                            end else begin
                                if (i_cmd == CMD_INS_HEAD)
                                    n_idx = '0;
                                else if (i_cmd == CMD_INS_TAIL)
                                    n_idx = r_count[AW-1:0];
                                else
                                    n_idx = AW'(pos_e - 1'b1);
                                if (CW'(n_idx) == r_count) begin
                                    // append: write straight in
                                    mem_we    = 1'b1;
                                    mem_waddr = n_idx;
                                    mem_wdata = i_item_value;
                                    n_count   = r_count + 1'b1;
                                end else begin
                                    n_ptr   = r_count;
                                    n_state = S_SHRD;
                                end
                            end
                        end
                        CMD_DEL_HEAD, CMD_DEL_POS, CMD_DEL_TAIL: begin
                            n_ins = 1'b0;
                            if (r_count == '0) begin
                                n_res_st = ST_EMPTY;
                            end else if (i_cmd == CMD_DEL_POS &&
                                         (pos_e == '0 || pos_e > cnt_e)) begin
                                n_res_st = ST_BADPOS;
                            end else begin
                                if (i_cmd == CMD_DEL_HEAD)
                                    n_idx = '0;
                                else if (i_cmd == CMD_DEL_TAIL)
                                    n_idx = AW'(r_count - 1'b1);
                                else
                                    n_idx = AW'(pos_e - 1'b1);
                                n_state = S_DRD;
                            end
                        end
                        CMD_SEARCH: begin
                            n_ptr   = '0;
                            n_state = S_SRD;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_res_st = ST_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_LRD;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = r_ret;
                end
            end
            S_SHRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_ins ? AW'(r_ptr - 1'b1) : AW'(r_ptr + 1'b1);
                n_state   = S_SHWR;
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = r_rd;
                if (r_ins) begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = (AW'(r_ptr - 1'b1) == r_idx) ? S_INSV : S_SHRD;
                end else if (r_ptr + 1'b1 == r_count - 1'b1) begin
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SHRD;
                end
            end
            S_INSV: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
                n_count   = r_count + 1'b1;
                n_state   = S_EMIT;
            end
            S_DRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_DCAP;
            end
            S_DCAP: begin
                n_res_val = r_rd;
                n_res_pos = 7'(CW'(r_idx) + 1'b1);
                n_ptr     = CW'(r_idx);
                if (CW'(r_idx) == r_count - 1'b1) begin
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SHRD;
                end
            end
            S_SRD: begin
                if (r_ptr == r_count) begin
                    n_res_st = ST_NOTFOUND;
                    n_state  = S_EMIT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_rd == r_val) begin
                    n_res_val = r_val;
                    n_res_pos = 7'(r_ptr + 1'b1);
                    n_state   = S_EMIT;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_LRD: begin
                mem_re  = 1'b1;
                n_state = S_LCAP;
            end
            S_LCAP: begin
                n_res_val  = r_rd;
                n_res_pos  = 7'(r_ptr + 1'b1);
                n_res_st   = ST_OK;
                n_res_last = (r_ptr + 1'b1 == r_count);
                n_ret      = (r_ptr + 1'b1 == r_count) ? S_IDLE : S_LRD;
                n_ptr      = r_ptr + 1'b1;
                n_state    = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_ovalid = out_load ? 1'b1 : (r_ovalid && i_out_stall);

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            r_rd <= r_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_ins      <= n_ins;
        r_val      <= n_val;
        r_res_val  <= n_res_val;
        r_res_pos  <= n_res_pos;
        r_res_st   <= n_res_st;
        r_res_last <= n_res_last;
        if (out_load) begin
            r_oval  <= r_res_val;
            r_opos  <= r_res_pos;
            r_ost   <= r_res_st;
            r_olast <= r_res_last;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_out_value    = r_oval;
    assign o_out_position = r_opos;
    assign o_status       = r_ost;
    assign o_last         = r_olast;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_count == CW'(DEPTH) &&
        (i_cmd == CMD_INS_HEAD || i_cmd == CMD_INS_POS || i_cmd == CMD_INS_TAIL)
        |=> r_count == $past(r_count))
        else $error("insert into full list changed count");
    a_stream_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == ST_OK)
        else $error("non-final result with error status");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output overwritten while stalled");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for ordered_list_engine. A behavioural list mirrors
// the block, each request's expected results are queued, and every output
// transaction is compared field by field against the oldest one queued.
// ============================================================================
module tb_top;
    import olist_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int IDLE_LIMIT  = 20000;

    typedef struct packed {
        t_value     value;
        logic [6:0] position;
        logic [2:0] status;
        logic       last;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_cmd;
    logic [6:0] i_position;
    t_value     i_item_value;
    logic       o_out_valid;
    logic       i_out_stall;
    t_value     o_out_value;
    logic [6:0] o_out_position;
    logic [2:0] o_status;
    logic       o_last;

    t_value  shadow_list[$];
    t_result pending_results[$];
    int      mismatch_count;
    int      results_seen;
    int      requests_sent;
    int      idle_cycles;
    bit      idle_enable;
    bit      hold_off;

    ordered_list_engine #(.DEPTH(LIST_DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_value    (o_out_value),
        .o_out_position (o_out_position),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // Generate the clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Queue one result
    function automatic void push_result(t_value v, int p, logic [2:0] st, logic lst);
        t_result r;
        r.value    = v;
        r.position = p[6:0];
        r.status   = st;
        r.last     = lst;
        pending_results.push_back(r);
    endfunction

    // Apply one request to the shadow list and queue what it should return
    function automatic void predict_request(logic [2:0] cmd, int pos, t_value val);
        int     n;
        int     idx;
        t_value removed;
        n = shadow_list.size();
        case (cmd)
            CMD_INS_HEAD, CMD_INS_POS, CMD_INS_TAIL: begin
                if (n >= LIST_DEPTH) begin
                    push_result(0, 0, ST_FULL, 1'b1);
                end else begin
                    if (cmd == CMD_INS_HEAD) pos = 1;
                    else if (cmd == CMD_INS_TAIL) pos = n + 1;
                    if (pos < 1 || pos > n + 1) begin
                        push_result(0, 0, ST_BADPOS, 1'b1);
                    end else begin
                        shadow_list.insert(pos - 1, val);
                        push_result(0, 0, ST_OK, 1'b1);
                    end
                end
            end
            CMD_DEL_HEAD, CMD_DEL_POS, CMD_DEL_TAIL: begin
                if (n == 0) begin
                    push_result(0, 0, ST_EMPTY, 1'b1);
                end else begin
                    if (cmd == CMD_DEL_HEAD) pos = 1;
                    else if (cmd == CMD_DEL_TAIL) pos = n;
                    if (pos < 1 || pos > n) begin
                        push_result(0, 0, ST_BADPOS, 1'b1);
                    end else begin
                        removed = shadow_list[pos - 1];
                        shadow_list.delete(pos - 1);
                        push_result(removed, pos, ST_OK, 1'b1);
                    end
                end
            end
            CMD_SEARCH: begin
                idx = -1;
                for (int i = 0; i < n; i++) begin
                    if (idx < 0 && shadow_list[i] == val) idx = i;
                end
                if (idx >= 0) push_result(val, idx + 1, ST_OK, 1'b1);
                else push_result(0, 0, ST_NOTFOUND, 1'b1);
            end
            default: begin
                if (n == 0) push_result(0, 0, ST_EMPTY, 1'b1);
                for (int i = 0; i < n; i++) begin
                    push_result(shadow_list[i], i + 1, ST_OK, i == n - 1);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        mismatch_count++;
    endtask

    // Send one request, with random idle cycles when enabled; valid stays
    // up after the accepting edge until the next request or idle replaces it
    task automatic send_request(logic [2:0] cmd, int pos, t_value val);
        while (idle_enable && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_position   <= pos[6:0];
        i_item_value <= val;
        predict_request(cmd, pos, val);
        requests_sent++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Random value: extremes now and then, sometimes any value, otherwise a small pool to get repeats
    function automatic t_value pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(15) - 8;
        endcase
    endfunction

    // Check each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.value)
                    report_mismatch("value", o_out_value, want.value);
                if (o_out_position !== want.position)
                    report_mismatch("position", o_out_position, want.position);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // Drive the output stall: random, a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off = 1'b0;
            end else begin
                i_out_stall <= idle_enable && ($urandom_range(99) < 22);
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("ordered_list_engine test failed");
            $finish;
        end
    end

    task automatic test_empty_list();
        send_request(CMD_DEL_HEAD, 0, 0);
        send_request(CMD_DEL_POS, 1, 0);
        send_request(CMD_DEL_TAIL, 0, 0);
        send_request(CMD_SEARCH, 0, 5);
        send_request(CMD_LIST, 0, 0);
        send_request(CMD_INS_POS, 0, 1);
        send_request(CMD_INS_POS, 2, 1);
    endtask

    task automatic test_basic_ops();
        send_request(CMD_INS_HEAD, 0, 32'sh7FFF_FFFF);
        send_request(CMD_DEL_TAIL, 0, 0);          // only element, list empties
        send_request(CMD_INS_TAIL, 127, 32'sh8000_0000);
        send_request(CMD_INS_POS, 1, -1);
        send_request(CMD_INS_POS, 3, 0);
        send_request(CMD_INS_HEAD, 0, 7);
        send_request(CMD_SEARCH, 0, 0);
        send_request(CMD_SEARCH, 0, 32'sh8000_0000);
        send_request(CMD_LIST, 0, 0);
        send_request(CMD_DEL_POS, 5, 0);
        send_request(CMD_DEL_POS, 0, 0);
        send_request(CMD_DEL_POS, 2, 0);
        send_request(CMD_DEL_HEAD, 0, 0);
        send_request(CMD_INS_POS, 127, 0);
    endtask

    task automatic test_full_list();
        while (shadow_list.size() < LIST_DEPTH) send_request(CMD_INS_TAIL, 0, $urandom);
        send_request(CMD_INS_HEAD, 0, 1);
        send_request(CMD_INS_POS, 100, 1);
        send_request(CMD_INS_TAIL, 0, 1);
        send_request(CMD_DEL_POS, 64, 0);
        send_request(CMD_DEL_POS, 65, 0);
        send_request(CMD_INS_POS, 64, 3);
        send_request(CMD_LIST, 0, 0);
        while (shadow_list.size() > 2) send_request(CMD_DEL_HEAD, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (30) send_request(CMD_INS_TAIL, 0, pick_value());
        send_request(CMD_LIST, 0, 0);
    endtask

    task automatic test_random(int count);
        int     n;
        logic [2:0] cmd;
        int     pos;
        for (int k = 0; k < count; k++) begin
            idle_enable = !(k >= count / 3 && k < count / 3 + 60);
            n = shadow_list.size();
            cmd = 3'($urandom_range(7));
            // Turn most lists into searches; lean towards inserts when short, deletes when long
            if (cmd == CMD_LIST && $urandom_range(3) != 0) cmd = CMD_SEARCH;
            if (n < 8 && $urandom_range(1)) cmd = 3'($urandom_range(2));
            if (n > 50 && $urandom_range(1)) cmd = 3'(3 + $urandom_range(2));
            if ($urandom_range(9) == 0) pos = $urandom_range(127);
            else pos = $urandom_range(n + 1);
            send_request(cmd, pos, pick_value());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= '0;
        i_position   <= '0;
        i_item_value <= '0;
        mismatch_count = 0;
        results_seen   = 0;
        requests_sent  = 0;
        idle_cycles    = 0;
        idle_enable    = 1'b1;
        hold_off       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_backpressure();
        test_random(180);

        // Drop valid after the last transaction, then drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Covered %0d requests and %0d results: empty and full list errors,",
                 requests_sent, results_seen);
        $display("bad positions, all eight operations and a long output hold-off.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ordered_list_engine test passed");
        end else begin
            $display("ordered_list_engine test failed");
        end
        $finish;
    end

endmodule
